[src/ctpo_pkg.sv]
// ----------------------------------------------------------------------------
// ctpo_pkg: shared types and constants for collision test and push-out
// beat structs for both channels, queue entry layout and shape codes
// ----------------------------------------------------------------------------
package ctpo_pkg;

  // shape pair codes
  localparam logic [1:0] OP_SPH_SPH = 2'd0;
  localparam logic [1:0] OP_CYL_CYL = 2'd1;
  localparam logic [1:0] OP_SPH_CYL = 2'd2;

  // default depth of the queue between front and back
  localparam int QDepthDefault = 4;

  // bits of the integer root and of each push-out quotient
  localparam int RootBits = 32;
  localparam int QuotBits = 32;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic [30:0]        a_radius;
    logic [30:0]        a_height;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [30:0]        b_radius;
    logic [30:0]        b_height;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic signed [31:0] new_b_z;
    logic               coincident;
  } out_item_t;

  // per-item context carried through both halves
  typedef struct packed {
    logic [1:0]         op;
    logic               hit;
    logic               coin;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [2:0]         d_neg;    // {z, y, x} sign of b - a
    logic [31:0]        d_mag_x;
    logic [31:0]        d_mag_y;
    logic [31:0]        d_mag_z;
    logic [31:0]        range;    // a_radius + b_radius
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [63:0] dist_sq;         // valid on a hit, below 2^64 there
  } q_item_t;

endpackage

[src/collision_test_and_push_out.sv]
// ----------------------------------------------------------------------------
// collision_test_and_push_out: shape pair overlap test and push-out
// sphere and cylinder pairs in Q16.16, one pair per beat
// ----------------------------------------------------------------------------
// Takes one shape pair per clock while in_stall is low and returns one result
// beat per pair, in order. Between the accepting edge and out_valid lie 3 front
// stages (differences, squares, compare), the queue, a load stage, a 32-stage
// root, one multiply stage, a 32-stage divide and the output register. The root
// and divide pipelines settle one bit per stage; the sustained rate is one pair
// per cycle while out_stall stays low.
module collision_test_and_push_out import ctpo_pkg::*; #(
  parameter int QDepth = QDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  // queue wiring between front and back
  logic    q_push, q_pop, q_full, q_empty;
  q_item_t q_wr, q_rd;

  // front: classify the pair and decide hit / coincident
  ctpo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_data   (q_wr),
    .q_full   (q_full)
  );

  // queue decouples the front stall from the output stall
  ctpo_fifo #(.Depth(QDepth)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: root, scale, divide and saturate into the result beat
  ctpo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

[src/ctpo_front.sv]
// ----------------------------------------------------------------------------
// ctpo_front: overlap classification
// differences, vertical reject, squares and the hit compare in three stages
// ----------------------------------------------------------------------------
module ctpo_front import ctpo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     q_push,
  output q_item_t  q_data,
  input  logic     q_full
);

  logic    adv;
  logic    s1_vld_r, s2_vld_r, s3_vld_r;
  ctx_t    s1_ctx_r, s2_ctx_r;
  ctx_t    s1_nxt;
  q_item_t s3_r, s3_nxt;
  logic [63:0] sq_x_r, sq_y_r, sq_z_r, rr_r;

  logic signed [32:0] dx, dy, dz;
  logic signed [32:0] ndx, ndy, ndz;
  logic signed [33:0] ay_e, by_e, b_top, a_top, a_rlo, a_rhi;
  logic rej_cyl, rej_sph;
  logic [65:0] sum;

  assign adv      = !(s3_vld_r && q_full);
  assign in_stall = !adv;
  assign q_push   = s3_vld_r && !q_full;
  assign q_data   = s3_r;

  always_comb begin
    dx = {in_data.b_x[31], in_data.b_x} - {in_data.a_x[31], in_data.a_x};
    dy = {in_data.b_y[31], in_data.b_y} - {in_data.a_y[31], in_data.a_y};
    dz = {in_data.b_z[31], in_data.b_z} - {in_data.a_z[31], in_data.a_z};
    ndx = -dx;
    ndy = -dy;
    ndz = -dz;
    ay_e  = {{2{in_data.a_y[31]}}, in_data.a_y};
    by_e  = {{2{in_data.b_y[31]}}, in_data.b_y};
    b_top = by_e + {3'b000, in_data.b_height};
    a_top = ay_e + {3'b000, in_data.a_height};
    a_rlo = ay_e - {3'b000, in_data.a_radius};
    a_rhi = ay_e + {3'b000, in_data.a_radius};
    rej_cyl = (ay_e > b_top) || (a_top < by_e);
    rej_sph = (a_rlo > b_top) || (a_rhi < by_e);

    s1_nxt.op   = in_data.op;
    // candidate flag until the distance compare
    s1_nxt.hit  = (in_data.op == OP_SPH_SPH) ||
                  ((in_data.op == OP_CYL_CYL) && !rej_cyl) ||
                  ((in_data.op == OP_SPH_CYL) && !rej_sph);
    s1_nxt.coin = 1'b0;
    s1_nxt.a_x  = in_data.a_x;
    s1_nxt.a_y  = in_data.a_y;
    s1_nxt.a_z  = in_data.a_z;
    s1_nxt.b_x  = in_data.b_x;
    s1_nxt.b_y  = in_data.b_y;
    s1_nxt.b_z  = in_data.b_z;
    s1_nxt.d_neg   = {dz[32], dy[32], dx[32]};
    s1_nxt.d_mag_x = dx[32] ? ndx[31:0] : dx[31:0];
    s1_nxt.d_mag_y = dy[32] ? ndy[31:0] : dy[31:0];
    s1_nxt.d_mag_z = dz[32] ? ndz[31:0] : dz[31:0];
    s1_nxt.range   = {1'b0, in_data.a_radius} + {1'b0, in_data.b_radius};
  end

  always_comb begin
    sum = {2'b00, sq_x_r} + {2'b00, sq_z_r} +
          ((s2_ctx_r.op == OP_SPH_SPH) ? {2'b00, sq_y_r} : 66'd0);
    s3_nxt.ctx      = s2_ctx_r;
    s3_nxt.ctx.hit  = s2_ctx_r.hit && (sum <= {2'b00, rr_r});
    s3_nxt.ctx.coin = s3_nxt.ctx.hit && (sum == 66'd0);
    s3_nxt.dist_sq  = sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx_r <= s1_nxt;
      s2_ctx_r <= s1_ctx_r;
      sq_x_r   <= s1_ctx_r.d_mag_x * s1_ctx_r.d_mag_x;
      sq_y_r   <= s1_ctx_r.d_mag_y * s1_ctx_r.d_mag_y;
      sq_z_r   <= s1_ctx_r.d_mag_z * s1_ctx_r.d_mag_z;
      rr_r     <= s1_ctx_r.range * s1_ctx_r.range;
      s3_r     <= s3_nxt;
    end
  end

endmodule

[src/ctpo_fifo.sv]
// ----------------------------------------------------------------------------
// ctpo_fifo: queue between classification and push-out
// small register fifo, lets front and back stall on their own
// ----------------------------------------------------------------------------
module ctpo_fifo import ctpo_pkg::*; #(
  parameter int Depth = QDepthDefault
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wr_data,
  input  logic    pop,
  output q_item_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_item_t         mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full    = (cnt_r == FullCnt);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");

endmodule

[src/ctpo_back.sv]
// ----------------------------------------------------------------------------
// ctpo_back: push-out pipeline
// bit-per-stage root, scale multiply, bit-per-stage divide, saturate
// ----------------------------------------------------------------------------
module ctpo_back import ctpo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  q_item_t   q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic adv;

  // root stages: index 0 is the load stage
  logic        rt_vld_r  [RootBits+1];
  ctx_t        rt_ctx_r  [RootBits+1];
  logic [63:0] rt_rem_r  [RootBits+1];
  logic [31:0] rt_root_r [RootBits+1];

  // divide stages: index 0 holds the products
  logic        dv_vld_r  [QuotBits+1];
  ctx_t        dv_ctx_r  [QuotBits+1];
  logic [31:0] dv_den_r  [QuotBits+1];
  logic [64:0] dv_rem_r  [QuotBits+1][3];
  logic [31:0] dv_quo_r  [QuotBits+1][3];

  logic      out_vld_r;
  out_item_t out_r, out_nxt;

  logic [63:0] prod [3];
  logic [31:0] mag  [3];

  assign adv       = !(out_vld_r && out_stall);
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    mag[0] = rt_ctx_r[RootBits].d_mag_x;
    mag[1] = rt_ctx_r[RootBits].d_mag_y;
    mag[2] = rt_ctx_r[RootBits].d_mag_z;
    for (int a = 0; a < 3; a++) begin
      prod[a] = mag[a] * rt_ctx_r[RootBits].range;
    end
  end

  function automatic logic signed [31:0] sat_move(logic signed [31:0] base,
                                                  logic neg, logic [31:0] q);
    logic signed [33:0] v;
    v = neg ? ({{2{base[31]}}, base} - {2'b00, q})
            : ({{2{base[31]}}, base} + {2'b00, q});
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  always_comb begin
    ctx_t c;
    c = dv_ctx_r[QuotBits];
    out_nxt.hit        = c.hit;
    out_nxt.coincident = c.coin;
    out_nxt.new_b_x    = c.b_x;
    out_nxt.new_b_y    = c.b_y;
    out_nxt.new_b_z    = c.b_z;
    if (c.hit && c.coin) begin
      out_nxt.new_b_x = c.a_x;
      out_nxt.new_b_z = c.a_z;
      if (c.op == OP_SPH_SPH) out_nxt.new_b_y = c.a_y;
    end else if (c.hit) begin
      out_nxt.new_b_x = sat_move(c.a_x, c.d_neg[0], dv_quo_r[QuotBits][0]);
      out_nxt.new_b_z = sat_move(c.a_z, c.d_neg[2], dv_quo_r[QuotBits][2]);
      if (c.op == OP_SPH_SPH) begin
        out_nxt.new_b_y = sat_move(c.a_y, c.d_neg[1], dv_quo_r[QuotBits][1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= RootBits; i++) rt_vld_r[i] <= 1'b0;
      for (int i = 0; i <= QuotBits; i++) dv_vld_r[i] <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      rt_vld_r[0] <= !q_empty;
      for (int i = 0; i < RootBits; i++) rt_vld_r[i+1] <= rt_vld_r[i];
      dv_vld_r[0] <= rt_vld_r[RootBits];
      for (int i = 0; i < QuotBits; i++) dv_vld_r[i+1] <= dv_vld_r[i];
      out_vld_r <= dv_vld_r[QuotBits];
    end
  end

  always_ff @(posedge clk) begin
    logic [65:0] term;
    logic [64:0] sub;
    if (adv) begin
      rt_ctx_r[0]  <= q_data.ctx;
      rt_rem_r[0]  <= q_data.dist_sq;
      rt_root_r[0] <= '0;
      // one root bit a stage, msb first
      for (int i = 0; i < RootBits; i++) begin
        term = ({34'd0, rt_root_r[i]} << (RootBits - i)) +
               (66'd1 << (2 * (RootBits - 1 - i)));
        rt_ctx_r[i+1] <= rt_ctx_r[i];
        if ({2'b00, rt_rem_r[i]} >= term) begin
          rt_rem_r[i+1]  <= rt_rem_r[i] - term[63:0];
          rt_root_r[i+1] <= rt_root_r[i] | (32'd1 << (RootBits - 1 - i));
        end else begin
          rt_rem_r[i+1]  <= rt_rem_r[i];
          rt_root_r[i+1] <= rt_root_r[i];
        end
      end
      // scaled numerators with half-divisor rounding
      dv_ctx_r[0] <= rt_ctx_r[RootBits];
      dv_den_r[0] <= rt_root_r[RootBits];
      for (int a = 0; a < 3; a++) begin
        dv_rem_r[0][a] <= {1'b0, prod[a]} + {34'd0, rt_root_r[RootBits][31:1]};
        dv_quo_r[0][a] <= '0;
      end
      // one quotient bit a stage per axis
      for (int i = 0; i < QuotBits; i++) begin
        dv_ctx_r[i+1] <= dv_ctx_r[i];
        dv_den_r[i+1] <= dv_den_r[i];
        sub = {33'd0, dv_den_r[i]} << (QuotBits - 1 - i);
        for (int a = 0; a < 3; a++) begin
          if (dv_rem_r[i][a] >= sub) begin
            dv_rem_r[i+1][a] <= dv_rem_r[i][a] - sub;
            dv_quo_r[i+1][a] <= dv_quo_r[i][a] | (32'd1 << (QuotBits - 1 - i));
          end else begin
            dv_rem_r[i+1][a] <= dv_rem_r[i][a];
            dv_quo_r[i+1][a] <= dv_quo_r[i][a];
          end
        end
      end
      out_r <= out_nxt;
    end
  end

  a_coin_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.coincident) |-> out_r.hit)
    else $error("coincident without hit");

endmodule
